>>> src/salc_pkg.sv
`timescale 1ns / 1ps
// package for the set-associative lru cache tag store
// geometry constants, derived widths, line and row types, outcome codes
package salc_pkg;

  localparam int SET_COUNT   = 64;
  localparam int WAYS        = 4;
  localparam int BLOCK_BYTES = 64;

  localparam int ADDR_W    = 32;
  localparam int STORE_TAG_W = 20;
  localparam int STAMP_W   = 32;
  localparam int PENALTY_W = 10;
  localparam int COST_W    = 11;
  localparam int OUTCOME_W = 2;
  localparam int SET_OUT_W = 6;
  localparam int WAY_OUT_W = 2;

  localparam int OFFSET_W = $clog2(BLOCK_BYTES);
  localparam int SET_W    = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int SET_BITS = $clog2(SET_COUNT);
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_LSB  = OFFSET_W + SET_BITS;

  localparam logic [PENALTY_W-1:0] PENALTY_RESET = PENALTY_W'(100);
  localparam logic [STAMP_W-1:0]   STAMP_MAX     = '1;

  localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_CLEAN = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_DIRTY = 2'd2;

  typedef struct packed {
    logic [STORE_TAG_W-1:0] tag;
    logic                   dirty;
    logic [STAMP_W-1:0]     last_use;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

endpackage

>>> src/salc_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces: access requests, access results, penalty writes
// depends on salc_pkg for field widths
interface salc_req_if;
  import salc_pkg::*;
  logic              valid;
  logic              ready;
  logic              access_is_write;
  logic [ADDR_W-1:0] address;
  modport source (output valid, access_is_write, address, input ready);
  modport sink   (input valid, access_is_write, address, output ready);
endinterface

interface salc_rsp_if;
  import salc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [STAMP_W-1:0]     access_number;
  logic [OUTCOME_W-1:0]   outcome;
  logic [SET_OUT_W-1:0]   set_number;
  logic [STORE_TAG_W-1:0] access_tag;
  logic [WAY_OUT_W-1:0]   chosen_way;
  logic [STORE_TAG_W-1:0] prior_tag;
  logic                   prior_valid;
  logic                   prior_dirty;
  logic [STAMP_W-1:0]     prior_last_use;
  logic [COST_W-1:0]      cost_cycles;
  modport source (output valid, access_number, outcome, set_number, access_tag, chosen_way,
                  prior_tag, prior_valid, prior_dirty, prior_last_use, cost_cycles,
                  input ready);
  modport sink   (input valid, access_number, outcome, set_number, access_tag, chosen_way,
                  prior_tag, prior_valid, prior_dirty, prior_last_use, cost_cycles,
                  output ready);
endinterface

interface salc_cfg_if;
  import salc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [PENALTY_W-1:0] miss_penalty;
  modport source (output valid, miss_penalty, input ready);
  modport sink   (input valid, miss_penalty, output ready);
endinterface

>>> src/set_assoc_lru_cache_tags_core.sv
`timescale 1ns / 1ps
// top level of the set-associative lru cache tag and state store
// depends on salc_pkg, the salc_*_if interfaces and salc_ram
//
// usage:
//   req  - one transfer per access: access_is_write and the byte address
//   rsp  - one transfer per access: outcome, way, prior line state, cost
//   cfg  - miss_penalty writes, always ready; write only while idle
// the set row (tag, dirty, last-use stamp of every way) lives in one ram
// with a registered read; valid bits are flops so reset clears them at once
// flow: the access is taken in the idle state while the ram row is read;
//   in the lookup state the way is chosen, the row written back and the result
//   registered, once the output register is free or being drained
// throughput: one access at a time, taken only while idle, as each does a read then write-back
//   of the single ram port pair; the next read always follows the write,
//   so back-to-back accesses to one set see the updated row
// reset: all ways invalid, access counter zero, miss_penalty 100, no result
// stall: a held result keeps its payload; the next access may be taken but
//   its lookup waits until the held result is transferred
module set_assoc_lru_cache_tags_core
  import salc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  salc_req_if.sink   req,
  salc_rsp_if.source rsp,
  salc_cfg_if.sink   cfg
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOOK = 1'b1;

  logic state;

  // latched request
  logic                   is_write_q;
  logic [SET_W-1:0]       set_q;
  logic [STORE_TAG_W-1:0] tag_q;

  logic [STAMP_W-1:0]   access_counter;
  logic [PENALTY_W-1:0] miss_penalty;

  // per-way valid bits for every set
  logic [SET_COUNT-1:0][WAYS-1:0] valid_bits;

  row_t rd_row;
  row_t wr_row;

  logic req_xfer;
  logic look_done;

  assign req.ready = (state == S_IDLE);
  assign req_xfer  = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  // lookup finishes when the output register is free or being drained
  assign look_done = (state == S_LOOK) && (!rsp.valid || rsp.ready);

  // ---------------------------------------------------------------- row store
  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SET_COUNT)
  ) u_row_ram (
    .clk   (clk),
    .we    (look_done),
    .waddr (set_q),
    .wdata (wr_row),
    .re    (req_xfer),
    .raddr (SET_W'(req.address >> OFFSET_W)),
    .rdata (rd_row)
  );

  // ---------------------------------------------------------------- way choice
  logic [WAYS-1:0]    vrow;
  logic               hit;
  logic [WAY_W-1:0]   hit_way;
  logic               inv_found;
  logic [WAY_W-1:0]   inv_way;
  logic [WAY_W-1:0]   lru_way;
  logic [STAMP_W-1:0] oldest;
  logic [WAY_W-1:0]   way;
  line_t              prior;
  logic               prior_v;
  logic [OUTCOME_W-1:0] outcome;
  logic [COST_W-1:0]    cost;

  assign vrow = valid_bits[set_q];

  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    lru_way   = '0;
    oldest    = rd_row[0].last_use;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && vrow[w] && (rd_row[w].tag == tag_q)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!inv_found && !vrow[w]) begin
        inv_found = 1'b1;
        inv_way   = WAY_W'(w);
      end
    end
    // strict compare keeps the lowest index on ties
    for (int w = 1; w < WAYS; w++) begin
      if (rd_row[w].last_use < oldest) begin
        oldest  = rd_row[w].last_use;
        lru_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    if (hit) begin
      way = hit_way;
    end else if (inv_found) begin
      way = inv_way;
    end else begin
      way = lru_way;
    end
    prior_v = vrow[way];
    // a never-filled way reads as all zeros
    prior   = prior_v ? rd_row[way] : '0;

    if (hit) begin
      outcome = OUT_HIT;
      cost    = COST_W'(1);
    end else if (prior_v && prior.dirty) begin
      outcome = OUT_DIRTY;
      cost    = COST_W'(1) + {miss_penalty, 1'b0};
    end else begin
      outcome = OUT_CLEAN;
      cost    = COST_W'(1) + COST_W'(miss_penalty);
    end

    // write-back row: only the chosen way changes
    wr_row               = rd_row;
    wr_row[way].last_use = access_counter;
    if (is_write_q) begin
      wr_row[way].dirty = 1'b1;
    end else if (!hit) begin
      wr_row[way].dirty = 1'b0;
    end else begin
      wr_row[way].dirty = prior.dirty;
    end
    if (!hit) begin
      wr_row[way].tag = tag_q;
    end else begin
      wr_row[way].tag = prior.tag;
    end
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      access_counter <= '0;
      miss_penalty   <= PENALTY_RESET;
      valid_bits     <= '0;
      rsp.valid      <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        miss_penalty <= cfg.miss_penalty;
      end
      // a finishing lookup refills the output register in the same cycle
      if (rsp.valid && rsp.ready && !look_done) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_xfer) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (look_done) begin
            state                  <= S_IDLE;
            rsp.valid              <= 1'b1;
            valid_bits[set_q][way] <= 1'b1;
            if (access_counter != STAMP_MAX) begin
              access_counter <= access_counter + STAMP_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- payload
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      is_write_q <= req.access_is_write;
      set_q      <= SET_W'(req.address >> OFFSET_W);
      tag_q      <= STORE_TAG_W'(req.address >> TAG_LSB);
    end
    if (look_done) begin
      rsp.access_number  <= access_counter;
      rsp.outcome        <= outcome;
      rsp.set_number     <= SET_OUT_W'(set_q);
      rsp.access_tag     <= tag_q;
      rsp.chosen_way     <= WAY_OUT_W'(way);
      rsp.prior_tag      <= prior.tag;
      rsp.prior_valid    <= prior_v;
      rsp.prior_dirty    <= prior.dirty;
      rsp.prior_last_use <= prior.last_use;
      rsp.cost_cycles    <= cost;
    end
  end

  // ---------------------------------------------------------------- checks
  // a taken access always moves to the lookup state
  a_take_to_look: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> (state == S_LOOK))
    else $error("access taken without lookup");

  // the counter never goes backwards
  a_counter_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (access_counter >= $past(access_counter)))
    else $error("access counter decreased");

  // a finished lookup always leaves a result behind
  a_done_result: assert property (@(posedge clk) disable iff (rst)
    look_done |=> rsp.valid)
    else $error("lookup finished without result");

  // a dirty miss must have evicted a valid dirty line
  a_dirty_victim: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.outcome == OUT_DIRTY)) |-> (rsp.prior_valid && rsp.prior_dirty))
    else $error("dirty miss on clean victim");

endmodule

>>> src/salc_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> tb/tb_set_assoc_lru_cache_tags_core.sv
`timescale 1ns / 1ps
// testbench for the set-associative lru cache tag store: directed and random accesses,
// penalty writes between phases, in-order checking against a behavioral model of the store
// depends on salc_pkg, the salc_*_if interfaces and set_assoc_lru_cache_tags_core
module tb_set_assoc_lru_cache_tags_core;
  import salc_pkg::*;

  localparam int LINE_TOTAL = SET_COUNT * WAYS;

  // one result transfer, field by field as on the rsp channel
  typedef struct {
    logic [STAMP_W-1:0]     access_number;
    logic [OUTCOME_W-1:0]   outcome;
    logic [SET_OUT_W-1:0]   set_number;
    logic [STORE_TAG_W-1:0] access_tag;
    logic [WAY_OUT_W-1:0]   chosen_way;
    logic [STORE_TAG_W-1:0] prior_tag;
    logic                   prior_valid;
    logic                   prior_dirty;
    logic [STAMP_W-1:0]     prior_last_use;
    logic [COST_W-1:0]      cost_cycles;
  } lookup_result_t;

  // shadow copy of the tag store; predicts one lookup per accepted access
  // and checks the result transfers in order
  class lru_tag_scoreboard;
    bit                   valid_bits [LINE_TOTAL];
    bit                   dirty_bits [LINE_TOTAL];
    bit [STORE_TAG_W-1:0] tag_bits   [LINE_TOTAL];
    bit [STAMP_W-1:0]     stamps     [LINE_TOTAL];
    bit [STAMP_W-1:0]     access_count;
    bit [PENALTY_W-1:0]   penalty;
    lookup_result_t       expected_lookups [$];
    int unsigned          mismatches;

    function new();
      foreach (valid_bits[i]) begin
        valid_bits[i] = 1'b0;
        dirty_bits[i] = 1'b0;
        tag_bits[i]   = '0;
        stamps[i]     = '0;
      end
      access_count = '0;
      penalty      = PENALTY_RESET;
      mismatches   = 0;
    endfunction

    function void set_penalty(bit [PENALTY_W-1:0] value);
      penalty = value;
    endfunction

    function int pending();
      return expected_lookups.size();
    endfunction

    // predict the lookup for one accepted access and update the shadow store
    function void note_access(bit is_write, bit [ADDR_W-1:0] addr);
      int unsigned          blk;
      int unsigned          set_idx;
      bit [STORE_TAG_W-1:0] tag;
      int unsigned          base;
      int unsigned          way;
      int unsigned          line;
      bit                   hit;
      bit                   found;
      bit [STAMP_W-1:0]     oldest;
      int unsigned          cost;
      lookup_result_t       exp_r;
      blk     = addr / BLOCK_BYTES;
      set_idx = blk % SET_COUNT;
      tag     = STORE_TAG_W'(blk / SET_COUNT);
      base    = set_idx * WAYS;
      hit     = 1'b0;
      found   = 1'b0;
      way     = 0;
      // matching valid way first
      for (int w = 0; w < WAYS; w++) begin
        if (!found && valid_bits[base+w] && tag_bits[base+w] == tag) begin
          hit   = 1'b1;
          found = 1'b1;
          way   = w;
        end
      end
      // then the lowest empty way
      for (int w = 0; w < WAYS; w++) begin
        if (!found && !valid_bits[base+w]) begin
          found = 1'b1;
          way   = w;
        end
      end
      // all full: oldest stamp, lowest index wins a tie
      if (!found) begin
        oldest = stamps[base];
        way    = 0;
        for (int w = 1; w < WAYS; w++) begin
          if (stamps[base+w] < oldest) begin
            oldest = stamps[base+w];
            way    = w;
          end
        end
      end
      line = base + way;

      exp_r.access_number  = access_count;
      exp_r.set_number     = SET_OUT_W'(set_idx);
      exp_r.access_tag     = tag;
      exp_r.chosen_way     = WAY_OUT_W'(way);
      exp_r.prior_tag      = tag_bits[line];
      exp_r.prior_valid    = valid_bits[line];
      exp_r.prior_dirty    = dirty_bits[line];
      exp_r.prior_last_use = stamps[line];
      if (hit) begin
        exp_r.outcome = OUT_HIT;
        cost          = 1;
      end else if (valid_bits[line] && dirty_bits[line]) begin
        exp_r.outcome = OUT_DIRTY;
        cost          = 1 + 2 * penalty;
      end else begin
        exp_r.outcome = OUT_CLEAN;
        cost          = 1 + penalty;
      end
      exp_r.cost_cycles = COST_W'(cost);
      expected_lookups.push_back(exp_r);

      stamps[line] = access_count;
      if (access_count != STAMP_MAX) access_count++;
      if (is_write) dirty_bits[line] = 1'b1;
      else if (!hit) dirty_bits[line] = 1'b0;
      if (!hit) begin
        valid_bits[line] = 1'b1;
        tag_bits[line]   = tag;
      end
    endfunction

    function void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(lookup_result_t got);
      lookup_result_t want;
      if (expected_lookups.size() == 0) begin
        $error("result transfer with no access pending");
        mismatches++;
        return;
      end
      want = expected_lookups.pop_front();
      check_field("access_number", want.access_number, got.access_number);
      check_field("outcome", want.outcome, got.outcome);
      check_field("set_number", want.set_number, got.set_number);
      check_field("access_tag", want.access_tag, got.access_tag);
      check_field("chosen_way", want.chosen_way, got.chosen_way);
      check_field("prior_tag", want.prior_tag, got.prior_tag);
      check_field("prior_valid", want.prior_valid, got.prior_valid);
      check_field("prior_dirty", want.prior_dirty, got.prior_dirty);
      check_field("prior_last_use", want.prior_last_use, got.prior_last_use);
      check_field("cost_cycles", want.cost_cycles, got.cost_cycles);
    endfunction
  endclass

  logic clk;
  logic rst;

  salc_req_if req_if ();
  salc_rsp_if rsp_if ();
  salc_cfg_if cfg_if ();

  set_assoc_lru_cache_tags_core DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  lru_tag_scoreboard sb = new();

  // when set, neither side idles
  bit no_gaps = 1'b0;

  // tag and set pools for the random part, so that sets fill and evict
  bit [STORE_TAG_W-1:0] tag_pool [6];
  int unsigned          hot_sets [4];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic bit take_gap();
    return !no_gaps && ($urandom_range(0, 99) < 10);
  endfunction

  function automatic bit [ADDR_W-1:0] make_address(longint unsigned tag, longint unsigned set_idx,
                                                   longint unsigned offset);
    return ADDR_W'((tag * SET_COUNT + set_idx) * BLOCK_BYTES + offset);
  endfunction

  // new pools per phase, extremes mixed in
  task automatic refresh_pools();
    int unsigned r;
    foreach (tag_pool[k]) begin
      r = $urandom_range(0, 7);
      tag_pool[k] = (r == 0) ? '0 : (r == 1) ? '1 : STORE_TAG_W'($urandom);
    end
    foreach (hot_sets[k]) begin
      r = $urandom_range(0, 7);
      hot_sets[k] = (r == 0) ? 0 : (r == 1) ? SET_COUNT - 1 : $urandom_range(0, SET_COUNT - 1);
    end
  endtask

  // mostly a few hot sets and a few tags per phase, some spread, some fully random
  function automatic bit [ADDR_W-1:0] random_address();
    int unsigned mode;
    int unsigned offset;
    mode   = $urandom_range(0, 99);
    offset = $urandom_range(0, BLOCK_BYTES - 1);
    if (mode < 75)
      return make_address(tag_pool[$urandom_range(0, 5)], hot_sets[$urandom_range(0, 3)], offset);
    else if (mode < 90)
      return make_address(tag_pool[$urandom_range(0, 5)], $urandom_range(0, SET_COUNT - 1), offset);
    else
      return $urandom;
  endfunction

  // one access transfer; entered and left just after a falling edge
  task automatic send_access(bit is_write, bit [ADDR_W-1:0] addr);
    while (take_gap()) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid           = 1'b1;
    req_if.access_is_write = is_write;
    req_if.address         = addr;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    sb.note_access(is_write, addr);
    @(negedge clk);
  endtask

  // penalty write; the caller makes sure the block is idle
  task automatic write_penalty(bit [PENALTY_W-1:0] value);
    cfg_if.valid        = 1'b1;
    cfg_if.miss_penalty = value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    sb.set_penalty(value);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // wait for every predicted result, then let the pipeline settle
  task automatic drain();
    req_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic random_phase(int unsigned count);
    refresh_pools();
    repeat (count) send_access($urandom_range(0, 1), random_address());
  endtask

  // result side: random back-pressure at the falling edge
  initial begin
    rsp_if.ready = 1'b1;
    forever begin
      @(negedge clk);
      rsp_if.ready = !take_gap();
    end
  end

  // result monitor: a transfer is sampled at the rising edge
  always @(posedge clk) begin
    lookup_result_t got;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got.access_number  = rsp_if.access_number;
      got.outcome        = rsp_if.outcome;
      got.set_number     = rsp_if.set_number;
      got.access_tag     = rsp_if.access_tag;
      got.chosen_way     = rsp_if.chosen_way;
      got.prior_tag      = rsp_if.prior_tag;
      got.prior_valid    = rsp_if.prior_valid;
      got.prior_dirty    = rsp_if.prior_dirty;
      got.prior_last_use = rsp_if.prior_last_use;
      got.cost_cycles    = rsp_if.cost_cycles;
      sb.check_result(got);
    end
  end

  // main sequence
  initial begin
    rst                    = 1'b1;
    req_if.valid           = 1'b0;
    req_if.access_is_write = 1'b0;
    req_if.address         = '0;
    cfg_if.valid           = 1'b0;
    cfg_if.miss_penalty    = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed part, reset penalty still in force
    send_access(1'b0, 32'h0000_0000);            // lowest address, fill of empty way 0
    send_access(1'b1, 32'hFFFF_FFFF);            // highest address, write miss
    send_access(1'b0, 32'hFFFF_FFC0);            // read hit on a dirty line
    send_access(1'b1, make_address(0, 0, 63));   // write hit, line turns dirty
    send_access(1'b0, make_address(1, 0, 0));    // fill ways 1..3 of set 0
    send_access(1'b0, make_address(2, 0, 5));
    send_access(1'b0, make_address(3, 0, 9));
    send_access(1'b0, make_address(4, 0, 0));    // lru victim is way 0, dirty: read clears it
    send_access(1'b0, make_address(0, 0, 1));    // clean lru victim
    send_access(1'b1, make_address(2, 0, 2));    // write hit refreshes way 2
    send_access(1'b1, make_address(5, 0, 3));    // write miss over a clean victim
    send_access(1'b1, make_address(6, 0, 4));    // write miss
    send_access(1'b0, make_address(7, 0, 8));    // clean victim evicted by a read
    send_access(1'b1, make_address(8, 0, 8));    // dirty victim evicted by a write
    send_access(1'b0, make_address(20'hFFFFF, 0, 0));   // highest tag in set 0
    send_access(1'b0, make_address(0, SET_COUNT - 1, 0)); // lowest tag in last set
    send_access(1'b1, make_address(0, SET_COUNT - 1, BLOCK_BYTES - 1));
    send_access(1'b0, make_address(20'hFFFFF, SET_COUNT - 1, 0));
    random_phase(320);
    drain();

    write_penalty('0);
    random_phase(320);
    drain();

    // long stretch with neither side idling
    no_gaps = 1'b1;
    write_penalty('1);
    random_phase(320);
    drain();
    no_gaps = 1'b0;

    write_penalty(PENALTY_W'(1));
    random_phase(320);
    drain();

    write_penalty(PENALTY_W'($urandom));
    random_phase(320);
    drain();

    // extra settle time for a stray result
    repeat (20) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
